>>> rtl/core/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg: shared definitions for the tree path min/max query block
// Field widths, command codes, parameter defaults and the jump table entry.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 20;
    localparam int DEPTH_W  = 10;

    localparam int NODES_DEFAULT  = 1024;
    localparam int LEVELS_DEFAULT = 10;

    localparam logic [DEPTH_W-1:0]  DEPTH_MAX   = {DEPTH_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONES = {WEIGHT_W{1'b1}};

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // one jump table entry: 2^j ancestor and weight bounds on that jump
    typedef struct packed {
        logic [NODE_W-1:0]   anc;
        logic [WEIGHT_W-1:0] wmin;
        logic [WEIGHT_W-1:0] wmax;
    } jump_entry_t;

endpackage

>>> rtl/core/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/tree_path_min_max_query.sv
// ----------------------------------------------------------------------------
// tree_path_min_max_query: binary-lifting path min/max on a weighted tree
// Keeps depth and jump tables in RAM; add builds a child's rows, query
// returns min and max edge weight on the path between two nodes.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the rows of node 0 and of root node 1
// before it takes words; a write to the root register sweeps the new root's
// rows. Add nodes parent first. An add makes one jump-table read and write per
// level, set by the single read port of the jump RAM and the level-to-level
// dependence. A query reads both depths, lifts the deeper node, then lifts both
// nodes (two RAM reads per level) and then hands the result over; equal nodes
// go straight to the hand-over. A new word is taken as soon as the sequencer is
// back in idle, even while a result still waits on the output.
module tree_path_min_max_query #(
    parameter int NODES  = tpq_pkg::NODES_DEFAULT,
    parameter int LEVELS = tpq_pkg::LEVELS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: root node
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpq_pkg::NODE_W-1:0]    cfg_data,
    // command words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [tpq_pkg::NODE_W-1:0]    node_a,
    input  logic [tpq_pkg::NODE_W-1:0]    node_b,
    input  logic [tpq_pkg::WEIGHT_W-1:0]  weight,
    // result words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tpq_pkg::WEIGHT_W-1:0]  path_min,
    output logic [tpq_pkg::WEIGHT_W-1:0]  path_max,
    output logic                          path_empty
);

    localparam int NW  = tpq_pkg::NODE_W;
    localparam int WW  = tpq_pkg::WEIGHT_W;
    localparam int DW  = tpq_pkg::DEPTH_W;
    localparam int NAW = $clog2(NODES);
    localparam int AW  = $clog2(NODES * LEVELS);
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int EW  = $bits(tpq_pkg::jump_entry_t);
    localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

    // sequencer states
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADD_DEP  = 4'd2;
    localparam logic [3:0] S_ADD_LOOP = 4'd3;
    localparam logic [3:0] S_Q_DA     = 4'd4;
    localparam logic [3:0] S_Q_DB     = 4'd5;
    localparam logic [3:0] S_L_ISS    = 4'd6;
    localparam logic [3:0] S_L_DAT    = 4'd7;
    localparam logic [3:0] S_L_END    = 4'd8;
    localparam logic [3:0] S_P_A      = 4'd9;
    localparam logic [3:0] S_P_B      = 4'd10;
    localparam logic [3:0] S_F_A      = 4'd11;
    localparam logic [3:0] S_F_B      = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // nodes outside the table read as the sentinel
    function automatic logic [NW-1:0] node_idx(input logic [NW-1:0] x);
        node_idx = (32'(x) < NODES) ? x : '0;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] node,
                                                input logic [LW-1:0] lvl);
        cell_addr = AW'(32'(node) * LEVELS + 32'(lvl));
    endfunction

    function automatic logic [WW-1:0] wmin(input logic [WW-1:0] x, input logic [WW-1:0] y);
        wmin = (x < y) ? x : y;
    endfunction

    function automatic logic [WW-1:0] wmax(input logic [WW-1:0] x, input logic [WW-1:0] y);
        wmax = (x > y) ? x : y;
    endfunction

    // control registers
    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic          boot_reg, boot_next;
    logic          out_valid_reg, out_valid_next;

    // data registers
    logic [NW-1:0]  a_reg, a_next;
    logic [NW-1:0]  b_reg, b_next;
    logic [NW-1:0]  clr_node_reg, clr_node_next;
    logic [WW-1:0]  w_reg, w_next;
    logic [DW-1:0]  da_reg, da_next;
    logic [LEVELS-1:0] k_reg, k_next;
    logic [WW-1:0]  lo_reg, lo_next;
    logic [WW-1:0]  hi_reg, hi_next;
    logic           emp_reg, emp_next;
    tpq_pkg::jump_entry_t cur_reg, cur_next;
    tpq_pkg::jump_entry_t ea_reg, ea_next;
    logic [WW-1:0]  path_min_reg, path_min_next;
    logic [WW-1:0]  path_max_reg, path_max_next;
    logic           path_empty_reg, path_empty_next;
    logic           fwd_hit_reg;
    tpq_pkg::jump_entry_t fwd_data_reg;

    // memory ports
    logic            dwe;
    logic [NAW-1:0]  dwaddr, draddr;
    logic [DW-1:0]   dwdata, drdata;
    logic            jwe;
    logic [AW-1:0]   jwaddr, jraddr;
    tpq_pkg::jump_entry_t jwdata, jrdata, jeff;
    logic [EW-1:0]   jrdata_raw;
    logic [NW-1:0]   rd_node, wr_node, dr_node, dw_node;
    logic [LW-1:0]   rd_lvl, wr_lvl;

    // helpers
    logic [NW-1:0]  in_a, in_b, pa, pb, na;
    logic [DW-1:0]  db, dsat;
    logic [DW+LEVELS-1:0] diff_ext;
    logic           in_acc, cfg_acc, out_free;

    tpq_ram #(.WIDTH(DW), .DEPTH(NODES)) u_depth_ram (
        .clk   (clk),
        .we    (dwe),
        .waddr (dwaddr),
        .wdata (dwdata),
        .raddr (draddr),
        .rdata (drdata)
    );

    tpq_ram #(.WIDTH(EW), .DEPTH(NODES * LEVELS)) u_jump_ram (
        .clk   (clk),
        .we    (jwe),
        .waddr (jwaddr),
        .wdata (jwdata),
        .raddr (jraddr),
        .rdata (jrdata_raw)
    );

    assign jrdata = jrdata_raw;
    // same-cycle write and read of one entry: take the written word
    assign jeff = fwd_hit_reg ? fwd_data_reg : jrdata;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_a = node_idx(node_a);
    assign in_b = node_idx(node_b);
    assign pa   = node_idx(jeff.anc);
    assign pb   = node_idx(ea_reg.anc);
    assign db   = drdata;
    assign dsat = (drdata == tpq_pkg::DEPTH_MAX) ? drdata : drdata + DW'(1);

    assign dwaddr = NAW'(32'(dw_node));
    assign draddr = NAW'(32'(dr_node));
    assign jwaddr = cell_addr(wr_node, wr_lvl);
    assign jraddr = cell_addr(rd_node, rd_lvl);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        boot_next       = boot_reg;
        out_valid_next  = out_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        clr_node_next   = clr_node_reg;
        w_next          = w_reg;
        da_next         = da_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        emp_next        = emp_reg;
        cur_next        = cur_reg;
        ea_next         = ea_reg;
        path_min_next   = path_min_reg;
        path_max_next   = path_max_reg;
        path_empty_next = path_empty_reg;
        dwe      = 1'b0;
        dw_node  = b_reg;
        dwdata   = dsat;
        dr_node  = a_reg;
        jwe      = 1'b0;
        wr_node  = b_reg;
        wr_lvl   = lvl_reg;
        jwdata   = cur_reg;
        rd_node  = a_reg;
        rd_lvl   = lvl_reg;
        na       = a_reg;
        diff_ext = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                jwe     = 1'b1;
                wr_node = clr_node_reg;
                jwdata  = '0;
                dwe     = (lvl_reg == '0);
                dw_node = clr_node_reg;
                dwdata  = '0;
                if (lvl_reg == LVL_TOP)
                begin
                    lvl_next = '0;
                    if (boot_reg)
                    begin
                        boot_next     = 1'b0;
                        clr_node_next = NW'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            S_IDLE:
            begin
                dr_node = in_a;
                if (cfg_acc)
                begin
                    if (32'(cfg_data) < NODES)
                    begin
                        clr_node_next = cfg_data;
                        lvl_next      = '0;
                        state_next    = S_CLR;
                    end
                end
                else if (in_acc)
                begin
                    a_next  = in_a;
                    b_next  = node_b;
                    w_next  = weight;
                    lo_next = tpq_pkg::WEIGHT_ONES;
                    hi_next = '0;
                    if (command == tpq_pkg::CMD_ADD)
                    begin
                        if (node_b != '0 && 32'(node_b) < NODES)
                        begin
                            state_next = S_ADD_DEP;
                        end
                    end
                    else
                    begin
                        b_next = in_b;
                        if (in_a == in_b)
                        begin
                            lo_next    = '0;
                            emp_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            emp_next   = 1'b0;
                            state_next = S_Q_DA;
                        end
                    end
                end
            end
            S_ADD_DEP:
            begin
                // child depth and level zero, then read the parent's level zero
                dwe      = 1'b1;
                jwe      = 1'b1;
                wr_lvl   = '0;
                jwdata   = '{anc: a_reg, wmin: w_reg, wmax: w_reg};
                cur_next = jwdata;
                rd_lvl   = '0;
                lvl_next = LW'(1);
                state_next = (LEVELS == 1) ? S_IDLE : S_ADD_LOOP;
            end
            S_ADD_LOOP:
            begin
                jwe    = 1'b1;
                jwdata = '{anc:  jeff.anc,
                           wmin: wmin(cur_reg.wmin, jeff.wmin),
                           wmax: wmax(cur_reg.wmax, jeff.wmax)};
                cur_next = jwdata;
                rd_node  = pa;
                if (lvl_reg == LVL_TOP)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            S_Q_DA:
            begin
                da_next    = drdata;
                dr_node    = b_reg;
                state_next = S_Q_DB;
            end
            S_Q_DB:
            begin
                // deeper node goes to a
                if (da_reg < db)
                begin
                    a_next   = b_reg;
                    b_next   = a_reg;
                    diff_ext = {{LEVELS{1'b0}}, db - da_reg};
                end
                else
                begin
                    diff_ext = {{LEVELS{1'b0}}, da_reg - db};
                end
                k_next     = diff_ext[LEVELS-1:0];
                lvl_next   = LVL_TOP;
                state_next = S_L_ISS;
            end
            S_L_ISS:
            begin
                if (k_reg[lvl_reg])
                begin
                    state_next = S_L_DAT;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = S_L_END;
                end
                else
                begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            S_L_DAT:
            begin
                lo_next = wmin(lo_reg, jeff.wmin);
                hi_next = wmax(hi_reg, jeff.wmax);
                a_next  = pa;
                if (lvl_reg == '0)
                begin
                    state_next = S_L_END;
                end
                else
                begin
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_L_ISS;
                end
            end
            S_L_END:
            begin
                rd_lvl = LVL_TOP;
                if (a_reg == b_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = S_P_A;
                end
            end
            S_P_A:
            begin
                ea_next    = jeff;
                rd_node    = b_reg;
                state_next = S_P_B;
            end
            S_P_B:
            begin
                // jeff holds b's entry, ea_reg holds a's entry
                na = a_reg;
                if (pb != pa)
                begin
                    lo_next = wmin(lo_reg, wmin(ea_reg.wmin, jeff.wmin));
                    hi_next = wmax(hi_reg, wmax(ea_reg.wmax, jeff.wmax));
                    a_next  = pb;
                    b_next  = pa;
                    na      = pb;
                end
                rd_node = na;
                if (lvl_reg == '0)
                begin
                    rd_lvl     = '0;
                    state_next = S_F_A;
                end
                else
                begin
                    rd_lvl     = lvl_reg - LW'(1);
                    lvl_next   = lvl_reg - LW'(1);
                    state_next = S_P_A;
                end
            end
            S_F_A:
            begin
                ea_next    = jeff;
                rd_node    = b_reg;
                rd_lvl     = '0;
                state_next = S_F_B;
            end
            S_F_B:
            begin
                lo_next    = wmin(lo_reg, wmin(ea_reg.wmin, jeff.wmin));
                hi_next    = wmax(hi_reg, wmax(ea_reg.wmax, jeff.wmax));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    path_min_next   = lo_reg;
                    path_max_next   = hi_reg;
                    path_empty_next = emp_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            lvl_reg       <= '0;
            boot_reg      <= 1'b1;
            clr_node_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            boot_reg      <= boot_next;
            clr_node_reg  <= clr_node_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        w_reg          <= w_next;
        da_reg         <= da_next;
        k_reg          <= k_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        emp_reg        <= emp_next;
        cur_reg        <= cur_next;
        ea_reg         <= ea_next;
        path_min_reg   <= path_min_next;
        path_max_reg   <= path_max_next;
        path_empty_reg <= path_empty_next;
        fwd_hit_reg    <= jwe && (jwaddr == jraddr);
        fwd_data_reg   <= jwdata;
    end

    assign out_valid  = out_valid_reg;
    assign path_min   = path_min_reg;
    assign path_max   = path_max_reg;
    assign path_empty = path_empty_reg;

    // an empty path reports zero bounds
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_empty |-> path_min == '0 && path_max == '0)
        else $error("empty path with nonzero bounds");

    // jump table is written only while adding or clearing
    a_jwe_states: assert property (@(posedge clk) disable iff (!rst_n)
        jwe |-> state_reg == S_ADD_DEP || state_reg == S_ADD_LOOP || state_reg == S_CLR)
        else $error("jump table write outside add or clear");

    // level zero of an add is written in the depth step only
    a_add_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_LOOP |-> lvl_reg != '0)
        else $error("add loop at level zero");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(path_min_reg) && $stable(path_max_reg))
        else $error("pending result overwritten");

endmodule

>>> tb/sv/tree_path_min_max_query_tb.sv
// ----------------------------------------------------------------------------
// tree_path_min_max_query_tb: self-checking bench for the tree path query
// Builds weighted trees with add words and asks path min/max queries. A
// binary-lifting predictor mirrors the depth and jump tables and gives the
// expected result of each accepted query not typed in the directed table.
// Covers a directed table, random trees under three idle profiles and root rewrites.
// ----------------------------------------------------------------------------
module tree_path_min_max_query_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_NODES  = 1024;
    localparam int NUM_LEVELS = 10;
    localparam int STALL_MAX  = 4000;
    localparam int SETTLE     = 64;
    localparam int W_ONES     = int'(tpq_pkg::WEIGHT_ONES);

    typedef struct packed {
        logic [tpq_pkg::WEIGHT_W-1:0] wmin;
        logic [tpq_pkg::WEIGHT_W-1:0] wmax;
        logic                         empty;
    } path_word_t;

    typedef struct {
        logic       cmd;
        int         a;
        int         b;
        int         w;
        bit         typed;
        path_word_t res;
    } vector_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tpq_pkg::NODE_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          command;
    logic [tpq_pkg::NODE_W-1:0]    node_a;
    logic [tpq_pkg::NODE_W-1:0]    node_b;
    logic [tpq_pkg::WEIGHT_W-1:0]  weight;
    logic                          out_valid;
    logic                          out_ready;
    logic [tpq_pkg::WEIGHT_W-1:0]  path_min;
    logic [tpq_pkg::WEIGHT_W-1:0]  path_max;
    logic                          path_empty;

    // mirrored tree tables
    logic [tpq_pkg::DEPTH_W-1:0]  tree_depth [NUM_NODES];
    logic [tpq_pkg::NODE_W-1:0]   tree_anc   [NUM_NODES][NUM_LEVELS];
    logic [tpq_pkg::WEIGHT_W-1:0] tree_min   [NUM_NODES][NUM_LEVELS];
    logic [tpq_pkg::WEIGHT_W-1:0] tree_max   [NUM_NODES][NUM_LEVELS];

    bit                  node_known [NUM_NODES];
    int                  known_list [$];
    path_word_t          pending_paths [$];

    int err_cnt;
    int send_idle;
    int recv_idle;
    int hold_req;
    int hold_ack;
    int hold_left;
    int quiet_cycles;

    tree_path_min_max_query #(
        .NODES  (NUM_NODES),
        .LEVELS (NUM_LEVELS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .node_a     (node_a),
        .node_b     (node_b),
        .weight     (weight),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_min   (path_min),
        .path_max   (path_max),
        .path_empty (path_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---- predictor ----

    function automatic void mark_known(int n);
        if (!node_known[n])
        begin
            node_known[n] = 1'b1;
            known_list.insert(known_list.size(), n);
        end
    endfunction

    function automatic void clear_node(int n);
        tree_depth[n] = '0;
        for (int j = 0; j < NUM_LEVELS; j++)
        begin
            tree_anc[n][j] = '0;
            tree_min[n][j] = '0;
            tree_max[n][j] = '0;
        end
    endfunction

    // hang child below parent; rows rebuilt level by level in place
    function automatic void hang_child(int parent, int child,
                                       logic [tpq_pkg::WEIGHT_W-1:0] w);
        int mid;
        logic [tpq_pkg::DEPTH_W-1:0] d;
        if (child == 0)
            return;
        d = tree_depth[parent];
        tree_depth[child] = (d == tpq_pkg::DEPTH_MAX) ? tpq_pkg::DEPTH_MAX : d + 1'b1;
        tree_anc[child][0] = tpq_pkg::NODE_W'(parent);
        tree_min[child][0] = w;
        tree_max[child][0] = w;
        for (int j = 1; j < NUM_LEVELS; j++)
        begin
            mid = int'(tree_anc[child][j-1]);
            tree_anc[child][j] = tree_anc[mid][j-1];
            tree_min[child][j] = (tree_min[child][j-1] < tree_min[mid][j-1]) ?
                                 tree_min[child][j-1] : tree_min[mid][j-1];
            tree_max[child][j] = (tree_max[child][j-1] > tree_max[mid][j-1]) ?
                                 tree_max[child][j-1] : tree_max[mid][j-1];
        end
        mark_known(child);
    endfunction

    function automatic path_word_t walk_path(int a, int b);
        path_word_t r;
        int tmp, pa, pb;
        logic [tpq_pkg::DEPTH_W-1:0] k;
        logic [tpq_pkg::WEIGHT_W-1:0] lo, hi;
        lo = tpq_pkg::WEIGHT_ONES;
        hi = '0;
        if (a == b)
        begin
            r.wmin = '0;
            r.wmax = '0;
            r.empty = 1'b1;
            return r;
        end
        if (tree_depth[a] < tree_depth[b])
        begin
            tmp = a;
            a = b;
            b = tmp;
        end
        k = tree_depth[a] - tree_depth[b];
        // bring the deeper endpoint up to the other's depth
        for (int j = NUM_LEVELS - 1; j >= 0; j--)
        begin
            if (k[j])
            begin
                if (tree_min[a][j] < lo) lo = tree_min[a][j];
                if (tree_max[a][j] > hi) hi = tree_max[a][j];
                a = int'(tree_anc[a][j]);
            end
        end
        // lift both to just below the common ancestor
        if (a != b)
        begin
            for (int j = NUM_LEVELS - 1; j >= 0; j--)
            begin
                pa = int'(tree_anc[a][j]);
                pb = int'(tree_anc[b][j]);
                if (pa != pb)
                begin
                    if (tree_min[a][j] < lo) lo = tree_min[a][j];
                    if (tree_min[b][j] < lo) lo = tree_min[b][j];
                    if (tree_max[a][j] > hi) hi = tree_max[a][j];
                    if (tree_max[b][j] > hi) hi = tree_max[b][j];
                    a = pa;
                    b = pb;
                end
            end
            if (tree_min[a][0] < lo) lo = tree_min[a][0];
            if (tree_min[b][0] < lo) lo = tree_min[b][0];
            if (tree_max[a][0] > hi) hi = tree_max[a][0];
            if (tree_max[b][0] > hi) hi = tree_max[b][0];
        end
        r.wmin = lo;
        r.wmax = hi;
        r.empty = 1'b0;
        return r;
    endfunction

    // ---- drivers ----

    // offer one command word; predict on acceptance
    task automatic push_word(logic cmd, int a, int b, int w,
                             bit typed, path_word_t typed_res);
        while (int'($urandom_range(99)) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        node_a   <= tpq_pkg::NODE_W'(a);
        node_b   <= tpq_pkg::NODE_W'(b);
        weight   <= tpq_pkg::WEIGHT_W'(w);
        do @(posedge clk); while (!in_ready);
        if (cmd == tpq_pkg::CMD_ADD)
            hang_child(a, b, tpq_pkg::WEIGHT_W'(w));
        else if (typed)
            pending_paths.insert(pending_paths.size(), typed_res);
        else
            pending_paths.insert(pending_paths.size(), walk_path(a, b));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_paths.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_root(int v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= tpq_pkg::NODE_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        clear_node(v);
        mark_known(v);
    endtask

    function automatic int any_known();
        return known_list[$urandom_range(known_list.size() - 1)];
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(7))
            0: return 0;
            1: return W_ONES;
            default: return int'($urandom_range(W_ONES));
        endcase
    endfunction

    task automatic random_words(int count);
        int r, a, b, tries;
        path_word_t none;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            r = int'($urandom_range(99));
            a = any_known();
            if (r < 45)
            begin
                // grow the tree with a fresh child
                tries = 0;
                do
                begin
                    b = int'($urandom_range(NUM_NODES - 1, 1));
                    tries++;
                end
                while (node_known[b] && tries < 64);
                push_word(tpq_pkg::CMD_ADD, a, b, pick_weight(), 1'b0, none);
            end
            else if (r < 85)
            begin
                b = ($urandom_range(9) == 0) ? a : any_known();
                push_word(tpq_pkg::CMD_QUERY, a, b, pick_weight(), 1'b0, none);
            end
            else if (r < 92)
            begin
                // rewrite a node that is already present
                do b = any_known(); while (b == 0);
                push_word(tpq_pkg::CMD_ADD, a, b, pick_weight(), 1'b0, none);
            end
            else if (r < 96)
            begin
                push_word(tpq_pkg::CMD_ADD, a, 0, pick_weight(), 1'b0, none);
            end
            else
            begin
                do b = any_known(); while (b == 0);
                push_word(tpq_pkg::CMD_ADD, b, b, pick_weight(), 1'b0, none);
            end
        end
    endtask

    // ---- receiver ready and long hold-off ----
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_ack  <= 0;
            hold_left <= 0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (int'($urandom_range(99)) >= recv_idle);
        end
    end

    // ---- result checker ----
    always @(posedge clk)
    begin
        path_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_paths.size() == 0)
            begin
                $display("%0t: unexpected result word min=%h max=%h empty=%b",
                         $time, path_min, path_max, path_empty);
                err_cnt++;
            end
            else
            begin
                want = pending_paths.pop_front();
                if (path_min !== want.wmin)
                begin
                    $display("%0t: path_min expected %h actual %h", $time, want.wmin, path_min);
                    err_cnt++;
                end
                if (path_max !== want.wmax)
                begin
                    $display("%0t: path_max expected %h actual %h", $time, want.wmax, path_max);
                    err_cnt++;
                end
                if (path_empty !== want.empty)
                begin
                    $display("%0t: path_empty expected %b actual %b",
                             $time, want.empty, path_empty);
                    err_cnt++;
                end
            end
        end
    end

    // ---- watchdog: cycles with no handshake on any channel ----
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("tree_path_min_max_query_tb: errors");
            $finish;
        end
    end

    // ---- main sequence ----
    initial
    begin
        vector_t    vec [$];
        vector_t    v;

        hold_req = 0;
        send_idle = 15;
        recv_idle = 84;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = tpq_pkg::CMD_ADD;
        node_a = '0;
        node_b = '0;
        weight = '0;

        // reset state: sentinel and root rows zero, root is node 1
        for (int n = 0; n < NUM_NODES; n++)
        begin
            node_known[n] = 1'b0;
            clear_node(n);
        end
        mark_known(0);
        mark_known(1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: cmd, a, b, weight, typed, {min, max, empty}
        vec = '{
            '{tpq_pkg::CMD_QUERY, 0,    0,    0,       1'b1, '{20'h0, 20'h0, 1'b1}},
            '{tpq_pkg::CMD_QUERY, 1,    1,    0,       1'b1, '{20'h0, 20'h0, 1'b1}},
            '{tpq_pkg::CMD_QUERY, 1,    0,    0,       1'b1, '{20'h0, 20'h0, 1'b0}},
            '{tpq_pkg::CMD_ADD,   1,    2,    W_ONES,  1'b0, '0},
            '{tpq_pkg::CMD_ADD,   2,    3,    0,       1'b0, '0},
            '{tpq_pkg::CMD_ADD,   1,    4,    'h12345, 1'b0, '0},
            '{tpq_pkg::CMD_ADD,   4,    5,    'h80000, 1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 3,    5,    0,       1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 5,    3,    W_ONES,  1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 2,    2,    0,       1'b1, '{20'h0, 20'h0, 1'b1}},
            '{tpq_pkg::CMD_ADD,   1,    0,    'h7,     1'b0, '0},
            '{tpq_pkg::CMD_ADD,   3,    3,    'h1,     1'b0, '0},
            '{tpq_pkg::CMD_ADD,   1,    2,    'h5,     1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 3,    4,    0,       1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 0,    5,    0,       1'b0, '0},
            '{tpq_pkg::CMD_ADD,   5,    1023, W_ONES,  1'b0, '0},
            '{tpq_pkg::CMD_ADD,   1023, 682,  'h55555, 1'b0, '0},
            '{tpq_pkg::CMD_ADD,   682,  341,  'hAAAAA, 1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 341,  3,    0,       1'b0, '0},
            '{tpq_pkg::CMD_QUERY, 1023, 1023, 0,       1'b1, '{20'h0, 20'h0, 1'b1}},
            '{tpq_pkg::CMD_QUERY, 2,    341,  0,       1'b0, '0}
        };
        foreach (vec[i])
        begin
            v = vec[i];
            push_word(v.cmd, v.a, v.b, v.w, v.typed, v.res);
        end

        // receiver stalls for a long stretch while words keep coming
        hold_req = hold_req + 1;
        random_words(195);

        write_root(1023);
        send_idle = 84;
        recv_idle = 15;
        random_words(195);

        write_root(512);
        send_idle = 0;
        recv_idle = 0;
        random_words(195);

        drain_results();
        if (err_cnt == 0)
            $display("tree_path_min_max_query_tb: clean");
        else
            $display("tree_path_min_max_query_tb: errors");
        $finish;
    end

endmodule
